// ===== rtl/b3i_pkg.sv =====
// b3i_pkg: shared widths, constants, register map and corner tag for the 3d box projector
// no dependencies; imported by b3i_div and box3d_to_image_box
`default_nettype none
package b3i_pkg;

	// number format and corner count
	localparam int FRAC_BITS     = 16;
	localparam int Q30_SHIFT     = 30 - FRAC_BITS;
	localparam int CORNER_COUNT  = 8;
	localparam int CORNER_W      = $clog2(CORNER_COUNT);

	// field widths
	localparam int COORD_W       = 32;
	localparam int DIM_IN_W      = 31;
	localparam int HEAD_W        = 20;
	localparam int EDGE_W        = 28;
	localparam int SIZE_W        = 13;

	// configuration port
	localparam int ENTRY_W       = 32;
	localparam int REG_W         = 2 * ENTRY_W;
	localparam int REG_COUNT     = 8;
	localparam int ADDR_LSB      = $clog2(REG_W / 8);
	localparam int ADDR_W        = ADDR_LSB + $clog2(REG_COUNT);
	localparam int PROJ_REGS     = 6;

	// projection and division datapath
	localparam int PROD_W        = 2 * ENTRY_W;
	localparam int TERM_W        = PROD_W - FRAC_BITS;
	localparam int IMG_W         = TERM_W + 2;
	localparam int DIV_CAP_LOG2  = 13;
	localparam int QUO_W         = DIV_CAP_LOG2 + FRAC_BITS;
	localparam int REM_W         = IMG_W + QUO_W;

	// cordic
	localparam int ANG_W           = 36;
	localparam int CRD_W           = 34;
	localparam int TRIG_W          = FRAC_BITS + 2;
	localparam int CORDIC_STEPS    = 28;
	localparam int STEPS_PER_STAGE = 2;
	localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;

	localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [CRD_W-1:0] GAIN_Q30    = 34'sd652032874;

	// image size defaults and bound
	localparam logic [SIZE_W-1:0] RST_WIDTH  = 13'd1242;
	localparam logic [SIZE_W-1:0] RST_HEIGHT = 13'd375;
	localparam logic [SIZE_W-1:0] MAX_DIM    = 13'd4096;

	typedef enum logic [2:0] {
		REG_P0A,
		REG_P0B,
		REG_P1A,
		REG_P1B,
		REG_P2A,
		REG_P2B,
		REG_WIDTH,
		REG_HEIGHT
	} reg_idx_t;

	typedef struct packed {
		logic first;
		logic last;
	} corner_tag_t;

	// arctangent of 2^-step in q6.30
	function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned step);
		logic signed [ANG_W-1:0] a;
		unique case (step)
			0:  a = 36'sh03243F6A8;
			1:  a = 36'sh01DAC6705;
			2:  a = 36'sh00FADBAFC;
			3:  a = 36'sh007F56EA6;
			4:  a = 36'sh003FEAB76;
			5:  a = 36'sh001FFD55B;
			6:  a = 36'sh000FFFAAA;
			7:  a = 36'sh0007FFF55;
			8:  a = 36'sh0003FFFEA;
			9:  a = 36'sh0001FFFFD;
			10: a = 36'sh0000FFFFF;
			11: a = 36'sh00007FFFF;
			12: a = 36'sh00003FFFF;
			13: a = 36'sh00001FFFF;
			14: a = 36'sh00000FFFF;
			15: a = 36'sh000007FFF;
			16: a = 36'sh000003FFF;
			17: a = 36'sh000001FFF;
			18: a = 36'sh000000FFF;
			19: a = 36'sh0000007FF;
			20: a = 36'sh0000003FF;
			21: a = 36'sh0000001FF;
			22: a = 36'sh0000000FF;
			23: a = 36'sh00000007F;
			24: a = 36'sh00000003F;
			25: a = 36'sh00000001F;
			26: a = 36'sh00000000F;
			27: a = 36'sh000000008;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/b3i_div.sv =====
// b3i_div: pipelined restoring divider for u/w and v/w, one bit per stage, one corner per cycle
// depends on b3i_pkg
`default_nettype none
module b3i_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire b3i_pkg::corner_tag_t              in_tag,
	input  wire logic signed [b3i_pkg::IMG_W-1:0]  in_u,
	input  wire logic signed [b3i_pkg::IMG_W-1:0]  in_v,
	input  wire logic signed [b3i_pkg::IMG_W-1:0]  in_w,
	output logic                                   out_valid,
	output b3i_pkg::corner_tag_t                   out_tag,
	output logic signed [b3i_pkg::IMG_W-1:0]       out_u,
	output logic signed [b3i_pkg::IMG_W-1:0]       out_v
);
	import b3i_pkg::*;

	localparam int LANES = 2;

	// entry stage: magnitudes and signs
	logic                    vld_s1;
	corner_tag_t             tag_s1;
	logic                    zero_s1;
	logic [IMG_W-1:0]        den_s1;
	logic signed [IMG_W-1:0] raw_s1 [0:LANES-1];
	logic                    neg_s1 [0:LANES-1];
	logic [IMG_W-1:0]        num_s1 [0:LANES-1];

	// bit stages, index 0 is the cap check stage
	logic                    vld_sb  [0:QUO_W];
	corner_tag_t             tag_sb  [0:QUO_W];
	logic                    zero_sb [0:QUO_W];
	logic [IMG_W-1:0]        den_sb  [0:QUO_W];
	logic [REM_W-1:0]        rem_sb  [0:LANES-1][0:QUO_W];
	logic [QUO_W-1:0]        quo_sb  [0:LANES-1][0:QUO_W];
	logic                    neg_sb  [0:LANES-1][0:QUO_W];
	logic                    cap_sb  [0:LANES-1][0:QUO_W];
	logic signed [IMG_W-1:0] raw_sb  [0:LANES-1][0:QUO_W];

	logic signed [IMG_W-1:0] lane_in [0:LANES-1];
	logic signed [IMG_W-1:0] lane_res [0:LANES-1];

	assign lane_in[0] = in_u;
	assign lane_in[1] = in_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_sb[0] <= 1'b0;
		end else begin
			vld_s1    <= in_valid;
			vld_sb[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= in_tag;
		zero_s1 <= (in_w == '0);
		den_s1  <= in_w[IMG_W-1] ? IMG_W'(-in_w) : IMG_W'(in_w);
		tag_sb[0]  <= tag_s1;
		zero_sb[0] <= zero_s1;
		den_sb[0]  <= den_s1;
	end

	genvar l, j;
	for (l = 0; l < LANES; l++) begin : g_lane
		always_ff @(posedge clk) begin
			raw_s1[l] <= lane_in[l];
			neg_s1[l] <= lane_in[l][IMG_W-1] ^ in_w[IMG_W-1];
			num_s1[l] <= lane_in[l][IMG_W-1] ? IMG_W'(-lane_in[l]) : IMG_W'(lane_in[l]);

			// integer quotient of 2^DIV_CAP_LOG2 or more saturates
			cap_sb[l][0] <= (REM_W'({num_s1[l], {FRAC_BITS{1'b0}}}) >=
				REM_W'({den_s1, {QUO_W{1'b0}}}));
			rem_sb[l][0] <= REM_W'({num_s1[l], {FRAC_BITS{1'b0}}});
			quo_sb[l][0] <= '0;
			neg_sb[l][0] <= neg_s1[l];
			raw_sb[l][0] <= raw_s1[l];
		end
	end

	for (j = 0; j < QUO_W; j++) begin : g_bit
		localparam int K = QUO_W - 1 - j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sb[j+1] <= 1'b0;
			end else begin
				vld_sb[j+1] <= vld_sb[j];
			end
		end

		always_ff @(posedge clk) begin
			tag_sb[j+1]  <= tag_sb[j];
			zero_sb[j+1] <= zero_sb[j];
			den_sb[j+1]  <= den_sb[j];
		end

		for (l = 0; l < LANES; l++) begin : g_lane_bit
			logic [REM_W-1:0] sub;
			logic             fit;

			assign sub = REM_W'(den_sb[j]) << K;
			assign fit = (rem_sb[l][j] >= sub);

			always_ff @(posedge clk) begin
				rem_sb[l][j+1] <= fit ? rem_sb[l][j] - sub : rem_sb[l][j];
				quo_sb[l][j+1] <= {quo_sb[l][j][QUO_W-2:0], fit};
				neg_sb[l][j+1] <= neg_sb[l][j];
				cap_sb[l][j+1] <= cap_sb[l][j];
				raw_sb[l][j+1] <= raw_sb[l][j];
			end
		end
	end

	// sign, saturation and zero depth bypass
	for (l = 0; l < LANES; l++) begin : g_fix
		logic [QUO_W:0] mag;

		assign mag = cap_sb[l][QUO_W] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, quo_sb[l][QUO_W]};
		assign lane_res[l] = zero_sb[QUO_W] ? raw_sb[l][QUO_W] :
			(neg_sb[l][QUO_W] ? -$signed(IMG_W'(mag)) : $signed(IMG_W'(mag)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_sb[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		out_tag <= tag_sb[QUO_W];
		out_u   <= lane_res[0];
		out_v   <= lane_res[1];
	end

endmodule
`default_nettype wire

// ===== rtl/box3d_to_image_box.sv =====
// box3d_to_image_box: image-plane bounding box of a 3d box through a configured 3x4 camera matrix
// depends on b3i_pkg and b3i_div
`default_nettype none
//
// channel   | direction | handshake                          | payload
// ----------+-----------+------------------------------------+------------------------------------
// box in    | in        | start, busy (beat when start & !busy) | center_x/y/z, box_length/width/
//           |           |                                    | height, heading
// edges out | out       | done, one cycle, cannot be held    | left_edge, top_edge, right_edge,
//           |           |                                    | bottom_edge
// config    | in/out    | apb, write when psel&penable&pwrite | paddr, pwdata, prdata, pready
//
// the eight corners share one projection and divide pipeline, one corner a cycle, so busy
// stays high after each accepted beat until the pacing counter has run down to zero
// the done strobe follows the accepting edge through the sine/cosine cordic with two
// steps a stage, the corner and projection stages, then one quotient bit per divider stage
// several boxes are in flight at once; nothing is kept from one box to the next
// reset clears all valid bits and loads the register defaults; the receiver cannot stall, so
// no stage ever waits
module box3d_to_image_box (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [b3i_pkg::COORD_W-1:0]    center_x,
	input  wire logic signed [b3i_pkg::COORD_W-1:0]    center_y,
	input  wire logic signed [b3i_pkg::COORD_W-1:0]    center_z,
	input  wire logic [b3i_pkg::DIM_IN_W-1:0]          box_length,
	input  wire logic [b3i_pkg::DIM_IN_W-1:0]          box_width,
	input  wire logic [b3i_pkg::DIM_IN_W-1:0]          box_height,
	input  wire logic signed [b3i_pkg::HEAD_W-1:0]     heading,
	output logic                                       done,
	output logic [b3i_pkg::EDGE_W-1:0]                 left_edge,
	output logic [b3i_pkg::EDGE_W-1:0]                 top_edge,
	output logic [b3i_pkg::EDGE_W-1:0]                 right_edge,
	output logic [b3i_pkg::EDGE_W-1:0]                 bottom_edge,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [b3i_pkg::ADDR_W-1:0]            paddr,
	input  wire logic [b3i_pkg::REG_W-1:0]             pwdata,
	output logic [b3i_pkg::REG_W-1:0]                  prdata,
	output logic                                       pready
);
	import b3i_pkg::*;

	localparam int GP_W  = TRIG_W + DIM_IN_W + 1;   // trig times box size
	localparam int GS_W  = GP_W + 1;                // sum of two such products
	localparam int XT_W  = GS_W + 1;                // shifted sum plus center
	localparam int PS_W  = TERM_W + 1;              // partial projection sums
	localparam logic signed [XT_W-1:0] COORD_MAX = (XT_W'(1) <<< (COORD_W - 1)) - XT_W'(1);
	localparam logic signed [XT_W-1:0] COORD_MIN = -COORD_MAX - XT_W'(1);
	localparam logic signed [CRD_W:0]  TRIG_RND  = (CRD_W+1)'(1) <<< (Q30_SHIFT - 1);
	localparam logic [CORNER_W-1:0]    LAST_IDX  = CORNER_W'(CORNER_COUNT - 1);

	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
		logic [DIM_IN_W-1:0]       len;
		logic [DIM_IN_W-1:0]       wid;
		logic [DIM_IN_W-1:0]       hgt;
	} box_t;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [XT_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		priority if (v > COORD_MAX) begin
			r = COORD_MAX[COORD_W-1:0];
		end else if (v < COORD_MIN) begin
			r = COORD_MIN[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [EDGE_W-1:0] clamp_edge(input logic signed [IMG_W-1:0] v,
			input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] sz;
		logic [EDGE_W-1:0] hi;
		logic [EDGE_W-1:0] r;
		priority if (size == '0) begin
			sz = SIZE_W'(1);
		end else if (size > MAX_DIM) begin
			sz = MAX_DIM;
		end else begin
			sz = size;
		end
		hi = EDGE_W'(sz - SIZE_W'(1)) << FRAC_BITS;
		priority if (v < 0) begin
			r = '0;
		end else if ($unsigned(v) > IMG_W'(hi)) begin
			r = hi;
		end else begin
			r = v[EDGE_W-1:0];
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- config registers
	logic [REG_W-1:0]  proj_q [0:PROJ_REGS-1];
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:ADDR_LSB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PROJ_REGS; i++) begin
				proj_q[i] <= '0;
			end
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_P0A:    proj_q[0] <= pwdata;
				REG_P0B:    proj_q[1] <= pwdata;
				REG_P1A:    proj_q[2] <= pwdata;
				REG_P1B:    proj_q[3] <= pwdata;
				REG_P2A:    proj_q[4] <= pwdata;
				REG_P2B:    proj_q[5] <= pwdata;
				REG_WIDTH:  width_q   <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: height_q  <= pwdata[SIZE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_P0A:    prdata = proj_q[0];
			REG_P0B:    prdata = proj_q[1];
			REG_P1A:    prdata = proj_q[2];
			REG_P1B:    prdata = proj_q[3];
			REG_P2A:    prdata = proj_q[4];
			REG_P2B:    prdata = proj_q[5];
			REG_WIDTH:  prdata = REG_W'(width_q);
			REG_HEIGHT: prdata = REG_W'(height_q);
		endcase
	end

	// matrix entries: "first" holds columns 0 and 1, "second" columns 2 and 3, high half first
	logic signed [ENTRY_W-1:0] ent [0:2][0:3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			ent[r][0] = $signed(proj_q[2*r][REG_W-1:ENTRY_W]);
			ent[r][1] = $signed(proj_q[2*r][ENTRY_W-1:0]);
			ent[r][2] = $signed(proj_q[2*r+1][REG_W-1:ENTRY_W]);
			ent[r][3] = $signed(proj_q[2*r+1][ENTRY_W-1:0]);
		end
	end

	// ---------------------------------------------------------------- input pacing
	logic                accept;
	logic [CORNER_W-1:0] gap_q;

	assign accept = start & ~busy;
	assign busy   = (gap_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (accept) begin
			gap_q <= LAST_IDX;
		end else if (gap_q != '0) begin
			gap_q <= gap_q - CORNER_W'(1);
		end
	end

	// ---------------------------------------------------------------- angle reduction
	logic signed [ANG_W-1:0] head_q30;
	logic signed [ANG_W-1:0] h_mod;
	logic                    vld_s1, vld_s2;
	logic signed [ANG_W-1:0] h_s1, h_s2;
	box_t                    box_s1, box_s2;

	// heading moved to q6.30, then remainder by two pi with the sign of the dividend
	assign head_q30 = $signed({{(ANG_W-HEAD_W){heading[HEAD_W-1]}}, heading}) <<< Q30_SHIFT;

	always_comb begin
		priority if (head_q30 >= TWO_PI_Q30) begin
			h_mod = head_q30 - TWO_PI_Q30;
		end else if (head_q30 <= -TWO_PI_Q30) begin
			h_mod = head_q30 + TWO_PI_Q30;
		end else begin
			h_mod = head_q30;
		end
	end

	// cordic stage arrays, index 0 is the folded angle
	logic                    vld_sc  [0:CORDIC_STAGES];
	logic signed [CRD_W-1:0] x_sc    [0:CORDIC_STAGES];
	logic signed [CRD_W-1:0] y_sc    [0:CORDIC_STAGES];
	logic signed [ANG_W-1:0] h_sc    [0:CORDIC_STAGES];
	logic                    flip_sc [0:CORDIC_STAGES];
	box_t                    box_sc  [0:CORDIC_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_sc[0] <= 1'b0;
		end else begin
			vld_s1    <= accept;
			vld_s2    <= vld_s1;
			vld_sc[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		h_s1   <= h_mod;
		box_s1 <= '{cx: center_x, cy: center_y, cz: center_z,
			len: box_length, wid: box_width, hgt: box_height};

		// wrap into [-pi, pi]
		priority if (h_s1 > PI_Q30) begin
			h_s2 <= h_s1 - TWO_PI_Q30;
		end else if (h_s1 < -PI_Q30) begin
			h_s2 <= h_s1 + TWO_PI_Q30;
		end else begin
			h_s2 <= h_s1;
		end
		box_s2 <= box_s1;

		// fold into [-pi/2, pi/2]; the fold negates sine and cosine
		priority if (h_s2 > HALF_PI_Q30) begin
			h_sc[0]    <= h_s2 - PI_Q30;
			flip_sc[0] <= 1'b1;
		end else if (h_s2 < -HALF_PI_Q30) begin
			h_sc[0]    <= h_s2 + PI_Q30;
			flip_sc[0] <= 1'b1;
		end else begin
			h_sc[0]    <= h_s2;
			flip_sc[0] <= 1'b0;
		end
		x_sc[0]   <= GAIN_Q30;
		y_sc[0]   <= '0;
		box_sc[0] <= box_s2;
	end

	// ---------------------------------------------------------------- cordic rotation
	genvar g;
	for (g = 0; g < CORDIC_STAGES; g++) begin : g_cord
		logic signed [CRD_W-1:0] xs [0:STEPS_PER_STAGE];
		logic signed [CRD_W-1:0] ys [0:STEPS_PER_STAGE];
		logic signed [ANG_W-1:0] hs [0:STEPS_PER_STAGE];

		always_comb begin
			xs[0] = x_sc[g];
			ys[0] = y_sc[g];
			hs[0] = h_sc[g];
			for (int k = 0; k < STEPS_PER_STAGE; k++) begin
				if (hs[k] >= 0) begin
					xs[k+1] = xs[k] - (ys[k] >>> (g * STEPS_PER_STAGE + k));
					ys[k+1] = ys[k] + (xs[k] >>> (g * STEPS_PER_STAGE + k));
					hs[k+1] = hs[k] - atan_q30(g * STEPS_PER_STAGE + k);
				end else begin
					xs[k+1] = xs[k] + (ys[k] >>> (g * STEPS_PER_STAGE + k));
					ys[k+1] = ys[k] - (xs[k] >>> (g * STEPS_PER_STAGE + k));
					hs[k+1] = hs[k] + atan_q30(g * STEPS_PER_STAGE + k);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sc[g+1] <= 1'b0;
			end else begin
				vld_sc[g+1] <= vld_sc[g];
			end
		end

		always_ff @(posedge clk) begin
			x_sc[g+1]    <= xs[STEPS_PER_STAGE];
			y_sc[g+1]    <= ys[STEPS_PER_STAGE];
			h_sc[g+1]    <= hs[STEPS_PER_STAGE];
			flip_sc[g+1] <= flip_sc[g];
			box_sc[g+1]  <= box_sc[g];
		end
	end

	// ---------------------------------------------------------------- trig rounding
	logic signed [CRD_W-1:0]  x_fix, y_fix;
	logic signed [CRD_W:0]    x_rnd, y_rnd;
	logic                     vld_s4;
	logic signed [TRIG_W-1:0] cs_s4, sn_s4;
	box_t                     box_s4;

	assign x_fix = flip_sc[CORDIC_STAGES] ? -x_sc[CORDIC_STAGES] : x_sc[CORDIC_STAGES];
	assign y_fix = flip_sc[CORDIC_STAGES] ? -y_sc[CORDIC_STAGES] : y_sc[CORDIC_STAGES];
	assign x_rnd = (CRD_W+1)'(x_fix) + TRIG_RND;
	assign y_rnd = (CRD_W+1)'(y_fix) + TRIG_RND;

	// ---------------------------------------------------------------- per-box products
	// the s5 registers load only on a valid box and then feed the corner sequencer
	logic                   vld_s5;
	logic signed [GP_W-1:0] cl_s5, sw_s5, sl_s5, cw_s5;
	box_t                   box_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s4 <= vld_sc[CORDIC_STAGES];
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		cs_s4  <= TRIG_W'(x_rnd >>> Q30_SHIFT);
		sn_s4  <= TRIG_W'(y_rnd >>> Q30_SHIFT);
		box_s4 <= box_sc[CORDIC_STAGES];
		if (vld_s4) begin
			cl_s5  <= cs_s4 * $signed({1'b0, box_s4.len});
			sw_s5  <= sn_s4 * $signed({1'b0, box_s4.wid});
			sl_s5  <= sn_s4 * $signed({1'b0, box_s4.len});
			cw_s5  <= cs_s4 * $signed({1'b0, box_s4.wid});
			box_s5 <= box_s4;
		end
	end

	// ---------------------------------------------------------------- corner sequencer
	logic                seq_run_q;
	logic [CORNER_W-1:0] seq_idx_q;
	logic                issue;
	logic [CORNER_W-1:0] cur_idx;

	assign issue   = vld_s5 | seq_run_q;
	assign cur_idx = vld_s5 ? '0 : seq_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_run_q <= 1'b0;
			seq_idx_q <= '0;
		end else if (issue) begin
			seq_run_q <= (cur_idx != LAST_IDX);
			seq_idx_q <= cur_idx + CORNER_W'(1);
		end
	end

	// corner sign pattern: bit 1 flips the length, bit 0 the width, bit 2 lifts by the height
	// c = -cos, so c*a takes the opposite sign of cos*len
	logic signed [GS_W-1:0] ca, sb, sa, cb;

	assign ca = cur_idx[1] ? GS_W'(cl_s5) : -GS_W'(cl_s5);
	assign sb = cur_idx[0] ? -GS_W'(sw_s5) : GS_W'(sw_s5);
	assign sa = cur_idx[1] ? -GS_W'(sl_s5) : GS_W'(sl_s5);
	assign cb = cur_idx[0] ? GS_W'(cw_s5) : -GS_W'(cw_s5);

	logic                        vld_s6;
	corner_tag_t                 tag_s6;
	logic signed [GS_W-1:0]      xs_s6, zs_s6;
	logic signed [COORD_W:0]     y_s6;
	logic signed [COORD_W-1:0]   cx_s6, cz_s6;

	logic                        vld_s7;
	corner_tag_t                 tag_s7;
	logic signed [COORD_W-1:0]   pt_s7 [0:2];

	logic signed [XT_W-1:0]      x_sum, z_sum;

	assign x_sum = XT_W'(xs_s6 >>> (FRAC_BITS + 1)) + XT_W'(cx_s6);
	assign z_sum = XT_W'(zs_s6 >>> (FRAC_BITS + 1)) + XT_W'(cz_s6);

	// ---------------------------------------------------------------- projection
	logic                      vld_s8;
	corner_tag_t               tag_s8;
	logic signed [PROD_W-1:0]  prod_s8 [0:2][0:2];

	logic                      vld_s9;
	corner_tag_t               tag_s9;
	logic signed [PS_W-1:0]    pa_s9 [0:2];
	logic signed [PS_W-1:0]    pb_s9 [0:2];

	logic                      vld_s10;
	corner_tag_t               tag_s10;
	logic signed [IMG_W-1:0]   img_s10 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s6  <= issue;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		tag_s6 <= '{first: (cur_idx == '0), last: (cur_idx == LAST_IDX)};
		xs_s6  <= ca - sb;
		zs_s6  <= sa + cb;
		y_s6   <= cur_idx[2] ?
			$signed({box_s5.cy[COORD_W-1], box_s5.cy}) - $signed({2'b00, box_s5.hgt}) :
			$signed({box_s5.cy[COORD_W-1], box_s5.cy});
		cx_s6  <= box_s5.cx;
		cz_s6  <= box_s5.cz;

		tag_s7   <= tag_s6;
		pt_s7[0] <= sat_coord(x_sum);
		pt_s7[1] <= sat_coord(XT_W'(y_s6));
		pt_s7[2] <= sat_coord(z_sum);

		tag_s8 <= tag_s7;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				prod_s8[r][k] <= ent[r][k] * pt_s7[k];
			end
		end

		// floor shift of each product, then the sum in two halves
		tag_s9 <= tag_s8;
		for (int r = 0; r < 3; r++) begin
			pa_s9[r] <= PS_W'(TERM_W'(prod_s8[r][0] >>> FRAC_BITS)) +
				PS_W'(TERM_W'(prod_s8[r][1] >>> FRAC_BITS));
			pb_s9[r] <= PS_W'(TERM_W'(prod_s8[r][2] >>> FRAC_BITS)) + PS_W'(ent[r][3]);
		end

		tag_s10 <= tag_s9;
		for (int r = 0; r < 3; r++) begin
			img_s10[r] <= IMG_W'(pa_s9[r]) + IMG_W'(pb_s9[r]);
		end
	end

	// ---------------------------------------------------------------- perspective divide
	logic                    dv_valid;
	corner_tag_t             dv_tag;
	logic signed [IMG_W-1:0] dv_u, dv_v;

	b3i_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s10),
		.in_tag    (tag_s10),
		.in_u      (img_s10[0]),
		.in_v      (img_s10[1]),
		.in_w      (img_s10[2]),
		.out_valid (dv_valid),
		.out_tag   (dv_tag),
		.out_u     (dv_u),
		.out_v     (dv_v)
	);

	// ---------------------------------------------------------------- min / max over corners
	logic signed [IMG_W-1:0] umin_q, umax_q, vmin_q, vmax_q;
	logic                    fin_s11;

	always_ff @(posedge clk) begin
		if (dv_valid) begin
			if (dv_tag.first || dv_u < umin_q) umin_q <= dv_u;
			if (dv_tag.first || dv_u > umax_q) umax_q <= dv_u;
			if (dv_tag.first || dv_v < vmin_q) vmin_q <= dv_v;
			if (dv_tag.first || dv_v > vmax_q) vmax_q <= dv_v;
		end
	end

	// ---------------------------------------------------------------- clamp and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s11 <= 1'b0;
			done    <= 1'b0;
		end else begin
			fin_s11 <= dv_valid & dv_tag.last;
			done    <= fin_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_s11) begin
			left_edge   <= clamp_edge(umin_q, width_q);
			right_edge  <= clamp_edge(umax_q, width_q);
			top_edge    <= clamp_edge(vmin_q, height_q);
			bottom_edge <= clamp_edge(vmax_q, height_q);
		end
	end

	// ---------------------------------------------------------------- checks
	// an accepted beat always closes the input for the corner slots
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("input not closed after accepted beat");

	// boxes never overlap in the corner sequencer
	a_seq_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		seq_run_q |-> !vld_s5)
		else $error("new box reached sequencer while corners still issuing");

	// one result beat per box, never back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// clamped minimum never passes clamped maximum
	a_edges_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (left_edge <= right_edge) && (top_edge <= bottom_edge))
		else $error("edges out of order");

endmodule
`default_nettype wire
